### hdl/blt_pkg.sv
// Shared types and constants of the boot list tokenizer.
package blt_pkg;

    localparam int NAME_BYTES_DEF = 10;
    localparam int NAMES_MAX_DEF  = 64;
    localparam int QUEUE_DEPTH    = 4;

    localparam int LIMIT_W     = 7;
    localparam int LEN_OUT_W   = 4;
    localparam int INDEX_OUT_W = 6;
    localparam int TOTAL_OUT_W = 7;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
    localparam logic [APB_ADDR_W-3:0] ADDR_NAME_LIMIT = '0;

    localparam logic [7:0] BYTE_SEP  = 8'h20;
    localparam logic [7:0] CHAR_AT   = 8'h40;
    localparam logic [7:0] CHAR_HASH = 8'h23;
    localparam logic [7:0] CHAR_BANG = 8'h21;

    localparam logic KIND_NAME = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef enum logic [1:0] {
        CLS_NAME,
        CLS_DROP,
        CLS_DIRECTIVE,
        CLS_FOLLOWER
    } t_token_class;

    // Which results one queued entry stands for.
    typedef struct packed {
        logic has_name;
        logic has_end;
    } t_result_flags;

endpackage

### hdl/blt_if.sv
// Channel interfaces of the boot list tokenizer.
interface blt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source(output valid, output data_byte, output last_byte, input ready);
    modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface blt_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [63:0] name_low_bytes;
    logic [15:0] name_high_bytes;
    logic [3:0]  name_length;
    logic [5:0]  name_index;
    logic [6:0]  name_total;

    modport source(output valid, output kind, output name_low_bytes,
                   output name_high_bytes, output name_length, output name_index,
                   output name_total, input ready);
    modport sink(input valid, input kind, input name_low_bytes,
                 input name_high_bytes, input name_length, input name_index,
                 input name_total, output ready);
endinterface

### hdl/blt_queue.sv
// Small flop-based queue between the front and the back part.
module blt_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end
endmodule

### hdl/blt_front.sv
// Front part: tracks tokens byte by byte and queues name and end results.
module blt_front #(
    parameter int NAME_BYTES = blt_pkg::NAME_BYTES_DEF,
    parameter int NAMES_MAX  = blt_pkg::NAMES_MAX_DEF,
    localparam int SEEN_W    = $clog2(NAME_BYTES + 1),
    localparam int CNT_W     = $clog2(NAMES_MAX + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_last_byte,
    input  logic [blt_pkg::LIMIT_W-1:0]   i_name_limit,
    input  logic                          i_queue_full,
    output logic                          o_push,
    output blt_pkg::t_result_flags        o_flags,
    output logic [NAME_BYTES*8-1:0]       o_name_buf,
    output logic [SEEN_W-1:0]             o_name_len,
    output logic [CNT_W-1:0]              o_count
);
    import blt_pkg::*;

    localparam int CMP_W = (LIMIT_W > CNT_W) ? LIMIT_W : CNT_W;

    logic                     r_inside, n_inside;
    logic [SEEN_W-1:0]        r_seen, n_seen;
    logic [NAME_BYTES*8-1:0]  r_buf, n_buf;
    t_token_class             r_class, n_class;
    logic                     r_skip, n_skip;
    logic [CNT_W-1:0]         r_count, n_count;

    logic                     w_accept;
    logic                     w_is_tok;
    logic                     w_finish;
    logic                     w_emit;
    logic [SEEN_W-1:0]        w_base;
    logic [SEEN_W-1:0]        w_len;
    logic [CMP_W-1:0]         w_limit;

    assign o_ready  = !i_queue_full;
    assign w_accept = i_valid && o_ready;
    assign w_is_tok = (i_data_byte >= BYTE_SEP);
    assign w_limit  = (CMP_W'(i_name_limit) > CMP_W'(NAMES_MAX)) ?
                      CMP_W'(NAMES_MAX) : CMP_W'(i_name_limit);

    always_comb begin
        n_inside = r_inside;
        n_seen   = r_seen;
        n_buf    = r_buf;
        n_class  = r_class;
        n_skip   = r_skip;
        n_count  = r_count;
        w_finish = 1'b0;
        w_emit   = 1'b0;
        w_base   = r_inside ? r_seen : '0;
        w_len    = r_seen;

        if (w_is_tok) begin
            if (!r_inside) begin
                n_inside = 1'b1;
                n_seen   = '0;
                if (r_skip) begin
                    n_class = CLS_FOLLOWER;
                    n_skip  = 1'b0;
                end else if (i_data_byte == CHAR_AT || i_data_byte == CHAR_HASH) begin
                    n_class = CLS_DROP;
                end else if (i_data_byte == CHAR_BANG) begin
                    n_class = CLS_DIRECTIVE;
                end else begin
                    n_class = CLS_NAME;
                end
            end
            // Bytes past the name width are not stored or counted.
            if (w_base < SEEN_W'(NAME_BYTES)) begin
                n_seen = w_base + 1'b1;
                for (int k = 0; k < NAME_BYTES; k++) begin
                    if (w_base == SEEN_W'(k)) begin
                        n_buf[8*k +: 8] = i_data_byte;
                    end
                end
            end else begin
                n_seen = w_base;
            end
            w_finish = i_last_byte;
        end else begin
            w_finish = r_inside;
        end

        w_len = n_seen;

        if (w_finish) begin
            n_inside = 1'b0;
            if (n_class == CLS_DIRECTIVE) begin
                n_skip = 1'b1;
            end else if (n_class == CLS_NAME && CMP_W'(r_count) < w_limit) begin
                w_emit  = 1'b1;
                n_count = r_count + 1'b1;
            end
        end

        // The list ends here: token state and name count start over.
        if (i_last_byte) begin
            n_inside = 1'b0;
            n_seen   = '0;
            n_class  = CLS_NAME;
            n_skip   = 1'b0;
            n_count  = '0;
        end
    end

    assign o_push           = w_accept && (w_emit || i_last_byte);
    assign o_flags.has_name = w_emit;
    assign o_flags.has_end  = i_last_byte;
    assign o_name_buf       = n_buf;
    assign o_name_len       = w_len;
    assign o_count          = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_seen   <= '0;
            r_class  <= CLS_NAME;
            r_skip   <= 1'b0;
            r_count  <= '0;
        end else if (w_accept) begin
            r_inside <= n_inside;
            r_seen   <= n_seen;
            r_class  <= n_class;
            r_skip   <= n_skip;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_buf <= n_buf;
        end
    end
endmodule

### hdl/blt_back.sv
// Back part: expands queued entries into result transactions and holds them.
module blt_back #(
    parameter int NAME_BYTES = blt_pkg::NAME_BYTES_DEF,
    parameter int NAMES_MAX  = blt_pkg::NAMES_MAX_DEF,
    localparam int SEEN_W    = $clog2(NAME_BYTES + 1),
    localparam int CNT_W     = $clog2(NAMES_MAX + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_empty,
    output logic                              o_pop,
    input  blt_pkg::t_result_flags            i_flags,
    input  logic [NAME_BYTES*8-1:0]           i_name_buf,
    input  logic [SEEN_W-1:0]                 i_name_len,
    input  logic [CNT_W-1:0]                  i_count,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_kind,
    output logic [63:0]                       o_name_low_bytes,
    output logic [15:0]                       o_name_high_bytes,
    output logic [blt_pkg::LEN_OUT_W-1:0]     o_name_length,
    output logic [blt_pkg::INDEX_OUT_W-1:0]   o_name_index,
    output logic [blt_pkg::TOTAL_OUT_W-1:0]   o_name_total
);
    import blt_pkg::*;

    localparam int PAD_BYTES = 16;

    logic                     r_valid, n_valid;
    logic                     r_name_done, n_name_done;
    logic                     r_kind, n_kind;
    logic [63:0]              r_low, n_low;
    logic [15:0]              r_high, n_high;
    logic [LEN_OUT_W-1:0]     r_len, n_len;
    logic [INDEX_OUT_W-1:0]   r_index, n_index;
    logic [TOTAL_OUT_W-1:0]   r_total, n_total;

    logic                     w_load;
    logic [PAD_BYTES*8-1:0]   w_pad;
    logic [63:0]              w_low;
    logic [15:0]              w_high;

    assign w_load = !r_valid || i_ready;

    // Only the bytes that belong to the token are shown; the rest read as zero.
    always_comb begin
        w_pad = '0;
        w_pad[NAME_BYTES*8-1:0] = i_name_buf;
        w_low  = '0;
        w_high = '0;
        for (int k = 0; k < 8; k++) begin
            if (k < int'(i_name_len)) begin
                w_low[8*k +: 8] = w_pad[8*k +: 8];
            end
        end
        for (int k = 0; k < 2; k++) begin
            if (k + 8 < int'(i_name_len)) begin
                w_high[8*k +: 8] = w_pad[8*(k+8) +: 8];
            end
        end
    end

    always_comb begin
        n_valid     = r_valid;
        n_name_done = r_name_done;
        n_kind      = r_kind;
        n_low       = r_low;
        n_high      = r_high;
        n_len       = r_len;
        n_index     = r_index;
        n_total     = r_total;
        o_pop       = 1'b0;

        if (w_load) begin
            n_valid = 1'b0;
            if (!i_empty) begin
                n_valid = 1'b1;
                if (i_flags.has_name && !r_name_done) begin
                    n_kind      = KIND_NAME;
                    n_low       = w_low;
                    n_high      = w_high;
                    n_len       = LEN_OUT_W'(i_name_len);
                    n_index     = INDEX_OUT_W'(i_count);
                    n_total     = '0;
                    // An entry with an end result stays for a second transaction.
                    n_name_done = i_flags.has_end;
                    o_pop       = !i_flags.has_end;
                end else begin
                    n_kind      = KIND_END;
                    n_low       = '0;
                    n_high      = '0;
                    n_len       = '0;
                    n_index     = '0;
                    n_total     = TOTAL_OUT_W'(i_count + CNT_W'(i_flags.has_name));
                    n_name_done = 1'b0;
                    o_pop       = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_name_done <= 1'b0;
        end else begin
            r_valid     <= n_valid;
            r_name_done <= n_name_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_low   <= n_low;
        r_high  <= n_high;
        r_len   <= n_len;
        r_index <= n_index;
        r_total <= n_total;
    end

    assign o_valid           = r_valid;
    assign o_kind            = r_kind;
    assign o_name_low_bytes  = r_low;
    assign o_name_high_bytes = r_high;
    assign o_name_length     = r_len;
    assign o_name_index      = r_index;
    assign o_name_total      = r_total;
endmodule

### hdl/boot_list_tokenizer.sv
// Top level of the boot list tokenizer: front, queue, back and the register port.
//
//   channel   dir   handshake            payload
//   i_in      in    valid/ready          data_byte, last_byte
//   o_out     out   valid/ready          kind, name_low/high_bytes, name_length,
//                                        name_index, name_total
//   APB       in    psel/penable/pready  name_limit at byte address 0
//
// One byte is taken per cycle while the queue is not full; a result passes through
// the queue and then the output register. A last byte that closes a name gives two
// transactions, which the back part sends one after the other from one queue entry.
// The four-entry queue lets input continue while the output is stalled; the
// input stalls only when the queue is full. Reset is synchronous and clears
// all token state, the queue and the output valid; name_limit returns to 64.
module boot_list_tokenizer #(
    parameter int NAME_BYTES = blt_pkg::NAME_BYTES_DEF,
    parameter int NAMES_MAX  = blt_pkg::NAMES_MAX_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    blt_in_if.sink                            i_in,
    blt_out_if.source                         o_out,
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [blt_pkg::APB_ADDR_W-1:0]    i_paddr,
    input  logic [blt_pkg::APB_DATA_W-1:0]    i_pwdata,
    output logic [blt_pkg::APB_DATA_W-1:0]    o_prdata,
    output logic                              o_pready
);
    import blt_pkg::*;

    localparam int SEEN_W  = $clog2(NAME_BYTES + 1);
    localparam int CNT_W   = $clog2(NAMES_MAX + 1);
    localparam int ENTRY_W = 2 + NAME_BYTES*8 + SEEN_W + CNT_W;

    logic [LIMIT_W-1:0]       r_name_limit;
    logic                     w_reg_hit;

    logic                     w_push;
    t_result_flags            w_push_flags;
    logic [NAME_BYTES*8-1:0]  w_push_buf;
    logic [SEEN_W-1:0]        w_push_len;
    logic [CNT_W-1:0]         w_push_count;
    logic                     w_full;

    logic                     w_pop;
    logic                     w_empty;
    logic [ENTRY_W-1:0]       w_head;
    t_result_flags            w_head_flags;
    logic [NAME_BYTES*8-1:0]  w_head_buf;
    logic [SEEN_W-1:0]        w_head_len;
    logic [CNT_W-1:0]         w_head_count;

    // Register port: word address in the upper address bits.
    assign o_pready  = 1'b1;
    assign w_reg_hit = (i_paddr[APB_ADDR_W-1:2] == ADDR_NAME_LIMIT);
    assign o_prdata  = w_reg_hit ? APB_DATA_W'(r_name_limit) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_limit <= LIMIT_RESET;
        end else if (i_psel && i_penable && i_pwrite && o_pready && w_reg_hit) begin
            r_name_limit <= i_pwdata[LIMIT_W-1:0];
        end
    end

    blt_front #(
        .NAME_BYTES(NAME_BYTES),
        .NAMES_MAX (NAMES_MAX)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .o_ready     (i_in.ready),
        .i_data_byte (i_in.data_byte),
        .i_last_byte (i_in.last_byte),
        .i_name_limit(r_name_limit),
        .i_queue_full(w_full),
        .o_push      (w_push),
        .o_flags     (w_push_flags),
        .o_name_buf  (w_push_buf),
        .o_name_len  (w_push_len),
        .o_count     (w_push_count)
    );

    blt_queue #(
        .WIDTH(ENTRY_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_data ({w_push_flags, w_push_buf, w_push_len, w_push_count}),
        .o_full (w_full),
        .i_pop  (w_pop),
        .o_empty(w_empty),
        .o_data (w_head)
    );

    assign {w_head_flags, w_head_buf, w_head_len, w_head_count} = w_head;

    blt_back #(
        .NAME_BYTES(NAME_BYTES),
        .NAMES_MAX (NAMES_MAX)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_empty          (w_empty),
        .o_pop            (w_pop),
        .i_flags          (w_head_flags),
        .i_name_buf       (w_head_buf),
        .i_name_len       (w_head_len),
        .i_count          (w_head_count),
        .o_valid          (o_out.valid),
        .i_ready          (o_out.ready),
        .o_kind           (o_out.kind),
        .o_name_low_bytes (o_out.name_low_bytes),
        .o_name_high_bytes(o_out.name_high_bytes),
        .o_name_length    (o_out.name_length),
        .o_name_index     (o_out.name_index),
        .o_name_total     (o_out.name_total)
    );
endmodule

### tb/tb_boot_list_tokenizer.sv
// Self-checking testbench of the boot list tokenizer with its name result predictor.
module tb_boot_list_tokenizer;
    import blt_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [63:0] name_low_bytes;
        logic [15:0] name_high_bytes;
        logic [3:0]  name_length;
        logic [5:0]  name_index;
        logic [6:0]  name_total;
    } t_list_result;

    class list_result_board;
        t_list_result expected_results[$];
        logic [6:0]   name_limit;
        bit           in_token;
        bit           skip_next;
        int unsigned  kept;
        int unsigned  names_out;
        logic [7:0]   token_text [NAME_BYTES_DEF];
        t_token_class token_class;
        int unsigned  mismatches;
        int unsigned  reported;
        int unsigned  results_seen;

        function new();
            name_limit = LIMIT_RESET;
            mismatches = 0;
            reported = 0;
            results_seen = 0;
            clear_list();
        endfunction

        function void clear_list();
            in_token = 1'b0;
            skip_next = 1'b0;
            kept = 0;
            names_out = 0;
            token_class = CLS_NAME;
        endfunction

        function void set_limit(logic [6:0] value);
            name_limit = value;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void close_token();
            t_list_result r;
            int unsigned cap;
            in_token = 1'b0;
            if (token_class == CLS_DIRECTIVE) begin
                skip_next = 1'b1;
                return;
            end
            if (token_class != CLS_NAME)
                return;
            cap = (name_limit > NAMES_MAX_DEF) ? NAMES_MAX_DEF : name_limit;
            if (names_out >= cap)
                return;
            r = '0;
            r.kind = KIND_NAME;
            for (int k = 0; k < kept; k++) begin
                if (k < 8)
                    r.name_low_bytes[8*k +: 8] = token_text[k];
                else
                    r.name_high_bytes[8*(k-8) +: 8] = token_text[k];
            end
            r.name_length = 4'(kept);
            r.name_index = 6'(names_out);
            expected_results.push_back(r);
            names_out++;
        endfunction

        // Called once per accepted input transaction.
        function void take_byte(logic [7:0] b, logic last);
            t_list_result r;
            if (b >= BYTE_SEP) begin
                if (!in_token) begin
                    in_token = 1'b1;
                    kept = 0;
                    if (skip_next) begin
                        token_class = CLS_FOLLOWER;
                        skip_next = 1'b0;
                    end else if (b == CHAR_AT || b == CHAR_HASH) begin
                        token_class = CLS_DROP;
                    end else if (b == CHAR_BANG) begin
                        token_class = CLS_DIRECTIVE;
                    end else begin
                        token_class = CLS_NAME;
                    end
                end
                if (kept < NAME_BYTES_DEF) begin
                    token_text[kept] = b;
                    kept++;
                end
                if (last)
                    close_token();
            end else if (in_token) begin
                close_token();
            end
            if (last) begin
                r = '0;
                r.kind = KIND_END;
                r.name_total = 7'(names_out);
                expected_results.push_back(r);
                clear_list();
            end
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (reported < 40) begin
                reported++;
                $display("%0t mismatch: %s", $time, msg);
            end
        endtask

        task compare_field(string field, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                          results_seen, field, got, want));
        endtask

        task check_result(t_list_result got);
            t_list_result want;
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing expected, kind %0d",
                                          results_seen, got.kind));
                return;
            end
            want = expected_results.pop_front();
            compare_field("kind", 64'(got.kind), 64'(want.kind));
            compare_field("name_low_bytes", got.name_low_bytes, want.name_low_bytes);
            compare_field("name_high_bytes", 64'(got.name_high_bytes),
                          64'(want.name_high_bytes));
            compare_field("name_length", 64'(got.name_length), 64'(want.name_length));
            compare_field("name_index", 64'(got.name_index), 64'(want.name_index));
            compare_field("name_total", 64'(got.name_total), 64'(want.name_total));
        endtask
    endclass

    localparam int LONG_HOLD      = 80;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WIND_DOWN      = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 250;
    localparam logic [6:0] PHASE_LIMITS [7] = '{7'd64, 7'd1, 7'd127, 7'd3, 7'd0, 7'd40, 7'd64};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_psel;
    logic                  i_penable;
    logic                  i_pwrite;
    logic [APB_ADDR_W-1:0] i_paddr;
    logic [APB_DATA_W-1:0] i_pwdata;
    logic [APB_DATA_W-1:0] o_prdata;
    logic                  o_pready;

    blt_in_if  in_ch();
    blt_out_if out_ch();

    list_result_board sb;
    bit sender_gaps;
    bit receiver_stalls;
    int unsigned long_hold_asks;
    int unsigned long_holds_done;

    boot_list_tokenizer uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .o_out     (out_ch),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] text_byte();
        return 8'($urandom_range(8'h20, 8'hFF));
    endfunction

    function automatic logic [7:0] sep_byte();
        return 8'($urandom_range(8'h00, 8'h1F));
    endfunction

    // Mostly well-formed lists; a few very long ones push past the name cap.
    function automatic void build_list(ref logic [7:0] q[$]);
        int unsigned n_tok;
        int unsigned kind;
        int unsigned len;
        bit big;
        logic [7:0] b;
        q.delete();
        big = ($urandom_range(0, 24) == 0);
        n_tok = big ? $urandom_range(66, 70) : $urandom_range(0, 8);
        for (int t = 0; t < n_tok; t++) begin
            kind = big ? 0 : $urandom_range(0, 9);
            if (big)
                len = $urandom_range(1, 3);
            else if ($urandom_range(0, 3) == 0)
                len = $urandom_range(1, 20);
            else
                len = $urandom_range(1, 10);
            if (t > 0 || $urandom_range(0, 1) == 1)
                repeat ($urandom_range(1, 3)) q.push_back(sep_byte());
            case (kind)
                6: q.push_back($urandom_range(0, 1) ? CHAR_AT : CHAR_HASH);
                7: q.push_back(CHAR_BANG);
                8: q.push_back(8'($urandom_range(0, 255)));
                default: begin
                    do b = text_byte();
                    while (b == CHAR_AT || b == CHAR_HASH || b == CHAR_BANG);
                    q.push_back(b);
                end
            endcase
            repeat (len - 1) q.push_back(kind == 8 ? 8'($urandom_range(0, 255)) : text_byte());
        end
        if (q.size() == 0 || $urandom_range(0, 1) == 1)
            q.push_back(sep_byte());
    endfunction

    task automatic send_byte(logic [7:0] b, logic last);
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.last_byte <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.take_byte(b, last);
    endtask

    task automatic send_list(input logic [7:0] q[$], input bit close);
        foreach (q[i])
            send_byte(q[i], close && (i == q.size() - 1));
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_name_limit(logic [6:0] value);
        logic [APB_DATA_W-1:0] word;
        word = $urandom();
        word[6:0] = value;
        i_psel <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite <= 1'b1;
        i_paddr <= {ADDR_NAME_LIMIT, 2'b00};
        i_pwdata <= word;
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        i_psel <= 1'b0;
        i_penable <= 1'b0;
        sb.set_limit(value);
    endtask

    // An open list is left unterminated so that the next phase continues it.
    task automatic run_random_phase(int unsigned quota, bit leave_open);
        int unsigned sent;
        logic [7:0] q[$];
        bit close;
        sent = 0;
        while (sent < quota) begin
            build_list(q);
            close = !(leave_open && sent + q.size() >= quota);
            send_list(q, close);
            sent += q.size();
        end
    endtask

    initial begin : result_sink
        t_list_result got;
        int unsigned hold_left;
        out_ch.ready = 1'b0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                got.kind = out_ch.kind;
                got.name_low_bytes = out_ch.name_low_bytes;
                got.name_high_bytes = out_ch.name_high_bytes;
                got.name_length = out_ch.name_length;
                got.name_index = out_ch.name_index;
                got.name_total = out_ch.name_total;
                sb.check_result(got);
            end
            if (long_hold_asks != long_holds_done) begin
                long_holds_done++;
                hold_left = LONG_HOLD;
            end else if (hold_left == 0 && receiver_stalls && $urandom_range(0, 5) == 0) begin
                hold_left = $urandom_range(1, 7);
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_boot_list_tokenizer: FAIL");
        $finish;
    end

    initial begin : main_flow
        logic [7:0] list_bytes[$];
        sb = new();
        sender_gaps = 1'b1;
        receiver_stalls = 1'b1;
        long_hold_asks = 0;
        long_holds_done = 0;
        i_rst_n = 1'b0;
        i_psel = 1'b0;
        i_penable = 1'b0;
        i_pwrite = 1'b0;
        i_paddr = '0;
        i_pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.last_byte = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Space and 0xFF inside a name, dropped tokens, a directive with its
        // follower, an overlong name and a name closed by the last byte.
        list_bytes = '{"A", 8'h20, 8'hFF, 8'h00, CHAR_AT, "x", 8'h1F, CHAR_HASH, 8'h0A,
                       CHAR_BANG, "z", 8'h01, "Q", "R", 8'h02,
                       8'h80, "a", "b", "c", "d", "e", "f", "g", "h", "i", "j", 8'h04, "K"};
        send_list(list_bytes, 1'b1);
        // A directive that ends the list, then a list of one separator.
        list_bytes = '{CHAR_BANG};
        send_list(list_bytes, 1'b1);
        list_bytes = '{8'h1F};
        send_list(list_bytes, 1'b1);

        wait_idle();
        write_name_limit(7'd1);
        list_bytes = '{"a", 8'h00, "b", 8'h00};
        send_list(list_bytes, 1'b1);
        wait_idle();
        write_name_limit(7'd0);
        list_bytes = '{"c"};
        send_list(list_bytes, 1'b1);
        // The cap drops below the count in the middle of a list.
        wait_idle();
        write_name_limit(7'd127);
        list_bytes = '{"d", 8'h00, "e", 8'h00};
        send_list(list_bytes, 1'b0);
        wait_idle();
        write_name_limit(7'd1);
        list_bytes = '{"f"};
        send_list(list_bytes, 1'b1);

        for (int p = 0; p < 7; p++) begin
            wait_idle();
            write_name_limit(p == 5 ? 7'($urandom_range(2, 63)) : PHASE_LIMITS[p]);
            sender_gaps = (p != 2 && p != 3 && p != 6);
            receiver_stalls = (p != 3 && p != 6);
            if (p == 2)
                long_hold_asks++;
            run_random_phase(PHASE_ITEMS, (p % 2 == 0) && p < 6);
        end

        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (WIND_DOWN) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("tb_boot_list_tokenizer: PASS");
        else
            $display("tb_boot_list_tokenizer: FAIL");
        $finish;
    end

endmodule
